// ===== rtl/gblur_pkg.sv =====
package gblur_pkg;

   // Field and register widths.
   localparam int GREY_W   = 8;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 13;
   localparam int SIDE_W   = 3;
   localparam int SCALE_W  = 16;
   localparam int ROW_W    = 14;
   localparam int NUM_COEF = 25;
   localparam int ACC_W    = 24;
   localparam int DIV_W    = ACC_W - 1;
   localparam int CSR_AW   = 6;
   localparam int CSR_DW   = 64;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_KERNEL = 5;

   // Register indexes, taken from csr_paddr[5:3].
   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_SIDE   = 3'd2;
   localparam logic [2:0] REG_SCALE  = 3'd3;
   localparam logic [2:0] REG_COEF0  = 3'd4;
   localparam logic [2:0] REG_COEF1  = 3'd5;
   localparam logic [2:0] REG_COEF2  = 3'd6;
   localparam logic [2:0] REG_COEF3  = 3'd7;

   // Item kinds on req_tuser.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_status_type;

   // Truncated mean of three channels: the sum times 683/2048 is exact here.
   function automatic logic [GREY_W-1:0] grey_of(input logic [7:0] r,
                                                 input logic [7:0] g,
                                                 input logic [7:0] b);
      logic [9:0]  sum;
      logic [19:0] prod;
      sum  = 10'(r) + 10'(g) + 10'(b);
      prod = 20'(sum) * 20'd683;
      return prod[18:11];
   endfunction

endpackage

// ===== rtl/gblur_line_store.sv =====
module gblur_line_store #(
   parameter int DEPTH  = 5120,
   parameter int ADDR_W = 13
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);
   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/gblur_div.sv =====
module gblur_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [gblur_pkg::DIV_W-1:0]     dividend,
   input  logic [gblur_pkg::SCALE_W-1:0]   divisor,
   output gblur_pkg::div_status_type       status
);
   import gblur_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SCALE_W-1:0] rem_ff, rem_in;
   logic [SCALE_W-1:0] dsr_ff, dsr_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [SCALE_W:0]   rem_sh;
   logic               fits;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
      fits    = rem_sh >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? SCALE_W'(rem_sh - {1'b0, dsr_ff}) : SCALE_W'(rem_sh);
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider finished without running");
endmodule

// ===== rtl/grey_gaussian_blur.sv =====
// Sequence: a pixel is converted to grey and written to the line store through ST_WQ and
// ST_WR; an item that gives a result then runs ST_TQ, ST_TRD and ST_TACC for each window tap,
// then ST_CHK, ST_DIV when the weighted sum is positive, and ST_RES. A drain item skips the write.
// Throughput: one item at a time, and a new item is taken only in ST_IDLE. The work per result
// is set by the single read port of the line store (one window tap at a time) and the bit-serial
// divider; a stalled result adds its wait.
// Reset: synchronous, active high; clears counters, handshakes and configuration registers, but not
// payload registers. The line store is not cleared; every entry the window reads is written first.
module grey_gaussian_blur #(
   parameter int MAX_WIDTH  = gblur_pkg::DEF_MAX_WIDTH,
   parameter int MAX_KERNEL = gblur_pkg::DEF_MAX_KERNEL
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input stream.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // red_in, green_in, blue_in
   input  logic                          req_tuser,   // req_type
   // Result stream.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // blurred_grey
   output logic                          rsp_tlast,   // last_of_frame
   // Configuration port.
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [gblur_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [gblur_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [gblur_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                          csr_pready
);
   import gblur_pkg::*;

   // Derived sizes. The line store holds MAX_KERNEL rows of MAX_WIDTH grey bytes,
   // and image row r lives in row slot r mod MAX_KERNEL.
   localparam int COL_W   = $clog2(MAX_WIDTH + 1);
   localparam int CA_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int DEPTH   = MAX_KERNEL * MAX_WIDTH;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SLOT_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int KS_W    = $clog2(MAX_KERNEL + 1);
   localparam int CI_W    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL * MAX_KERNEL) : 1;
   localparam int SW      = ROW_W + 2;
   localparam int PL_W    = ROW_W + COL_W;
   // The row slot comes from a multiplication by the reciprocal of MAX_KERNEL.
   localparam int SLOT_SH = ROW_W + 3;
   localparam int RECIP_W = SLOT_SH + 1;
   localparam int RECIP   = (2 ** SLOT_SH + MAX_KERNEL - 1) / MAX_KERNEL;
   localparam int MUL_W   = ROW_W + RECIP_W;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_WQ   = 4'd1;  // slot quotient of the row being written
   localparam logic [3:0] ST_WR   = 4'd2;  // grey byte into the line store
   localparam logic [3:0] ST_TQ   = 4'd3;  // tap position, range check, coefficient
   localparam logic [3:0] ST_TRD  = 4'd4;  // line store read for the tap
   localparam logic [3:0] ST_TACC = 4'd5;  // multiply and accumulate
   localparam logic [3:0] ST_CHK  = 4'd6;  // sign test, divider start
   localparam logic [3:0] ST_DIV  = 4'd7;
   localparam logic [3:0] ST_RES  = 4'd8;  // hand the result to the output register

   // ---------------------------------------------------------------------------------
   // Configuration registers. Each sits at byte address 8*i; a write lands on the edge at
   // which psel, penable and pwrite are high (pready is always high).
   // ---------------------------------------------------------------------------------
   logic [WIDTH_W-1:0]  cfg_width_ff;
   logic [HEIGHT_W-1:0] cfg_height_ff;
   logic [SIDE_W-1:0]   cfg_side_ff;
   logic [SCALE_W-1:0]  cfg_scale_ff;
   logic [63:0]         cfg_coef0_ff, cfg_coef1_ff, cfg_coef2_ff;
   logic [7:0]          cfg_coef3_ff;
   logic                csr_wr;
   logic [2:0]          csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= WIDTH_W'(640);
         cfg_height_ff <= HEIGHT_W'(480);
         cfg_side_ff   <= SIDE_W'(5);
         cfg_scale_ff  <= SCALE_W'(1);
         cfg_coef0_ff  <= '0;
         cfg_coef1_ff  <= '0;
         cfg_coef2_ff  <= '0;
         cfg_coef3_ff  <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_WIDTH:  cfg_width_ff  <= csr_pwdata[WIDTH_W-1:0];
            REG_HEIGHT: cfg_height_ff <= csr_pwdata[HEIGHT_W-1:0];
            REG_SIDE:   cfg_side_ff   <= csr_pwdata[SIDE_W-1:0];
            REG_SCALE:  cfg_scale_ff  <= csr_pwdata[SCALE_W-1:0];
            REG_COEF0:  cfg_coef0_ff  <= csr_pwdata;
            REG_COEF1:  cfg_coef1_ff  <= csr_pwdata;
            REG_COEF2:  cfg_coef2_ff  <= csr_pwdata;
            REG_COEF3:  cfg_coef3_ff  <= csr_pwdata[7:0];
            default:    cfg_coef3_ff  <= cfg_coef3_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_WIDTH:  csr_prdata = CSR_DW'(cfg_width_ff);
         REG_HEIGHT: csr_prdata = CSR_DW'(cfg_height_ff);
         REG_SIDE:   csr_prdata = CSR_DW'(cfg_side_ff);
         REG_SCALE:  csr_prdata = CSR_DW'(cfg_scale_ff);
         REG_COEF0:  csr_prdata = cfg_coef0_ff;
         REG_COEF1:  csr_prdata = cfg_coef1_ff;
         REG_COEF2:  csr_prdata = cfg_coef2_ff;
         REG_COEF3:  csr_prdata = CSR_DW'(cfg_coef3_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // Effective values: out-of-range settings are pulled into range.
   logic [COL_W-1:0]    w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [KS_W-1:0]     k_eff, half, lag_d;
   logic [SCALE_W-1:0]  scale_eff;
   logic signed [7:0]   coef_arr [NUM_COEF];

   always_comb begin
      if (cfg_width_ff == '0) begin
         w_eff = COL_W'(1);
      end else if (32'(cfg_width_ff) > MAX_WIDTH) begin
         w_eff = COL_W'(MAX_WIDTH);
      end else begin
         w_eff = COL_W'(cfg_width_ff);
      end
      h_eff = (cfg_height_ff == '0) ? HEIGHT_W'(1) : cfg_height_ff;
      if (cfg_side_ff == '0) begin
         k_eff = KS_W'(1);
      end else if (32'(cfg_side_ff) > MAX_KERNEL) begin
         k_eff = KS_W'(MAX_KERNEL);
      end else begin
         k_eff = KS_W'(cfg_side_ff);
      end
      half      = k_eff >> 1;
      lag_d     = k_eff - KS_W'(1) - half;
      scale_eff = (cfg_scale_ff == '0) ? SCALE_W'(1) : cfg_scale_ff;
   end

   for (genvar c = 0; c < NUM_COEF; c++) begin : g_coef
      if (c < 8) begin : g_w0
         assign coef_arr[c] = $signed(cfg_coef0_ff[8*c +: 8]);
      end else if (c < 16) begin : g_w1
         assign coef_arr[c] = $signed(cfg_coef1_ff[8*(c-8) +: 8]);
      end else if (c < 24) begin : g_w2
         assign coef_arr[c] = $signed(cfg_coef2_ff[8*(c-16) +: 8]);
      end else begin : g_w3
         assign coef_arr[c] = $signed(cfg_coef3_ff);
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequencer state and counters.
   // ---------------------------------------------------------------------------------
   logic [3:0]          state_ff, state_in;
   logic [COL_W-1:0]    in_col_ff, in_col_in;
   logic [ROW_W-1:0]    in_row_ff, in_row_in;
   logic [COL_W-1:0]    out_col_ff, out_col_in;
   logic [ROW_W-1:0]    out_row_ff, out_row_in;
   logic                frame_done_ff, frame_done_in;
   logic [KS_W-1:0]     ti_ff, ti_in, tj_ff, tj_in;
   logic [CI_W-1:0]     ci_ff, ci_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_grey_ff, rsp_grey_in;
   logic                rsp_last_ff, rsp_last_in;

   // Payload registers.
   logic [ROW_W-1:0]      wr_row_ff, wr_row_in;
   logic [CA_W-1:0]       wr_col_ff, wr_col_in;
   logic [7:0]            grey_ff, grey_in;
   logic                  emit_ff, emit_in;
   logic [ROW_W-1:0]      q_ff, q_in;
   logic [ROW_W-1:0]      tap_row_ff, tap_row_in;
   logic [CA_W-1:0]       tap_col_ff, tap_col_in;
   logic                  tap_ok_ff, tap_ok_in;
   logic signed [7:0]     coef_ff, coef_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [7:0]            res_ff, res_in;

   logic                  req_xfer;
   logic                  wrap;
   logic [COL_W-1:0]      col_a, col_n;
   logic [ROW_W-1:0]      row_w, row_a, h_row;
   logic [PL_W-1:0]       pos_lin, lag_lin;
   logic signed [SW-1:0]  a_s, b_s;
   logic [ROW_W-1:0]      mul_row;
   logic [MUL_W-1:0]      mul_q;
   logic [ROW_W-1:0]      addr_row;
   logic [CA_W-1:0]       addr_col;
   logic [ROW_W-1:0]      slot_full;
   logic [ADDR_W-1:0]     mem_addr;
   logic [7:0]            mem_rdata;
   logic                  mem_we;
   logic [5:0]            ci_ext;
   logic signed [16:0]    prod;
   logic                  last_tap;
   logic                  last_out;
   logic                  div_start;
   div_status_type        div_st;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign h_row      = ROW_W'(h_eff);

   // Position of the incoming pixel after the row wrap and the bottom clamp, and its
   // place in raster order against the lag of lag_d rows and lag_d pixels.
   always_comb begin
      wrap    = in_col_ff >= w_eff;
      col_a   = wrap ? '0 : in_col_ff;
      row_w   = wrap ? in_row_ff + ROW_W'(1) : in_row_ff;
      row_a   = (row_w >= h_row) ? h_row - ROW_W'(1) : row_w;
      col_n   = col_a + COL_W'(1);
      pos_lin = PL_W'(row_a) * PL_W'(w_eff) + PL_W'(col_a);
      lag_lin = PL_W'(lag_d) * PL_W'(w_eff) + PL_W'(lag_d);
   end

   // Window tap position relative to the result pixel.
   always_comb begin
      a_s = $signed(SW'(out_col_ff)) + $signed(SW'(ti_ff)) - $signed(SW'(half));
      b_s = $signed(SW'(out_row_ff)) + $signed(SW'(tj_ff)) - $signed(SW'(half));
   end

   // Row slot: quotient by reciprocal multiplication, registered, then the remainder.
   assign mul_row   = (state_ff == ST_WQ) ? wr_row_ff : b_s[ROW_W-1:0];
   assign mul_q     = MUL_W'(mul_row) * MUL_W'(RECIP);
   assign addr_row  = (state_ff == ST_WR) ? wr_row_ff : tap_row_ff;
   assign addr_col  = (state_ff == ST_WR) ? wr_col_ff : tap_col_ff;
   assign slot_full = addr_row - ROW_W'(q_ff * ROW_W'(MAX_KERNEL));
   assign mem_addr  = ADDR_W'(slot_full[SLOT_W-1:0]) * ADDR_W'(MAX_WIDTH)
                    + ADDR_W'(addr_col);
   assign mem_we    = (state_ff == ST_WR);

   assign ci_ext   = 6'(ci_ff);
   assign prod     = coef_ff * $signed({1'b0, mem_rdata});
   assign last_tap = (ti_ff == k_eff - KS_W'(1)) && (tj_ff == k_eff - KS_W'(1));
   assign last_out = (out_row_ff >= h_row - ROW_W'(1))
                  && (out_col_ff >= w_eff - COL_W'(1));

   always_comb begin
      state_in      = state_ff;
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      frame_done_in = frame_done_ff;
      ti_in         = ti_ff;
      tj_in         = tj_ff;
      ci_in         = ci_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_grey_in   = rsp_grey_ff;
      rsp_last_in   = rsp_last_ff;
      wr_row_in     = wr_row_ff;
      wr_col_in     = wr_col_ff;
      grey_in       = grey_ff;
      emit_in       = emit_ff;
      q_in          = q_ff;
      tap_row_in    = tap_row_ff;
      tap_col_in    = tap_col_ff;
      tap_ok_in     = tap_ok_ff;
      coef_in       = coef_ff;
      acc_in        = acc_ff;
      res_in        = res_ff;
      div_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            ti_in  = '0;
            tj_in  = '0;
            ci_in  = '0;
            acc_in = '0;
            if (req_xfer) begin
               if (req_tuser == KIND_DRAIN) begin
                  // A drain item only counts once the whole frame is in.
                  if (frame_done_ff) begin
                     state_in = ST_TQ;
                  end
               end else if (!frame_done_ff) begin
                  wr_row_in = row_a;
                  wr_col_in = col_a[CA_W-1:0];
                  grey_in   = grey_of(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
                  // A result is due once the input leads by lag_d rows and lag_d pixels.
                  emit_in   = pos_lin >= lag_lin;
                  if (col_n >= w_eff) begin
                     in_col_in = '0;
                     in_row_in = row_a + ROW_W'(1);
                     if (row_a + ROW_W'(1) >= h_row) begin
                        frame_done_in = 1'b1;
                     end
                  end else begin
                     in_col_in = col_n;
                     in_row_in = row_a;
                  end
                  state_in = ST_WQ;
               end
            end
         end
         ST_WQ: begin
            q_in     = ROW_W'(mul_q[MUL_W-1:SLOT_SH]);
            state_in = ST_WR;
         end
         ST_WR: begin
            state_in = emit_ff ? ST_TQ : ST_IDLE;
         end
         ST_TQ: begin
            q_in       = ROW_W'(mul_q[MUL_W-1:SLOT_SH]);
            tap_row_in = b_s[ROW_W-1:0];
            tap_col_in = a_s[CA_W-1:0];
            // Neighbours outside the image are skipped, which pads with zeros.
            tap_ok_in  = (a_s >= 0) && (b_s >= 0)
                      && (a_s < $signed(SW'(w_eff))) && (b_s < $signed(SW'(h_eff)));
            coef_in    = (ci_ext < 6'(NUM_COEF)) ? coef_arr[ci_ext[4:0]] : 8'sd0;
            state_in   = ST_TRD;
         end
         ST_TRD: begin
            state_in = ST_TACC;
         end
         ST_TACC: begin
            if (tap_ok_ff) begin
               acc_in = acc_ff + ACC_W'(prod);
            end
            ci_in = ci_ff + CI_W'(1);
            if (ti_ff == k_eff - KS_W'(1)) begin
               ti_in = '0;
               tj_in = tj_ff + KS_W'(1);
            end else begin
               ti_in = ti_ff + KS_W'(1);
            end
            state_in = last_tap ? ST_CHK : ST_TQ;
         end
         ST_CHK: begin
            // A sum that is not positive divides to zero or below and clamps to zero.
            if (acc_ff <= 0) begin
               res_in   = '0;
               state_in = ST_RES;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_st.done) begin
               res_in   = (div_st.quotient > DIV_W'(255)) ? 8'd255 : div_st.quotient[7:0];
               state_in = ST_RES;
            end
         end
         ST_RES: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_grey_in  = res_ff;
               rsp_last_in  = last_out;
               if (last_out) begin
                  // Frame complete: every position returns to the top left.
                  in_col_in     = '0;
                  in_row_in     = '0;
                  out_col_in    = '0;
                  out_row_in    = '0;
                  frame_done_in = 1'b0;
               end else if (out_col_ff + COL_W'(1) >= w_eff) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + ROW_W'(1);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         frame_done_ff <= 1'b0;
         ti_ff         <= '0;
         tj_ff         <= '0;
         ci_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         frame_done_ff <= frame_done_in;
         ti_ff         <= ti_in;
         tj_ff         <= tj_in;
         ci_ff         <= ci_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_grey_ff <= rsp_grey_in;
      rsp_last_ff <= rsp_last_in;
      wr_row_ff   <= wr_row_in;
      wr_col_ff   <= wr_col_in;
      grey_ff     <= grey_in;
      emit_ff     <= emit_in;
      q_ff        <= q_in;
      tap_row_ff  <= tap_row_in;
      tap_col_ff  <= tap_col_in;
      tap_ok_ff   <= tap_ok_in;
      coef_ff     <= coef_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_grey_ff;
   assign rsp_tlast  = rsp_last_ff;

   gblur_line_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_addr),
      .wr_data (grey_ff),
      .rd_addr (mem_addr),
      .rd_data (mem_rdata)
   );

   gblur_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff[DIV_W-1:0]),
      .divisor  (scale_eff),
      .status   (div_st)
   );

   // Once the whole frame is in, the input column waits at the start of a row.
   a_done_col: assert property (@(posedge clock) disable iff (reset)
      frame_done_ff |-> (in_col_ff == '0))
      else $error("input column not at row start after frame end");

   // The divider only reports while the sequencer waits for it.
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (state_ff == ST_DIV))
      else $error("divider result outside the divide state");

   // A new result transfer is offered only from the result state.
   a_rsp_from_res: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RES))
      else $error("result offered outside the result state");
endmodule

// ===== tb/grey_gaussian_blur_test.sv =====
`timescale 1ns / 1ps

module grey_gaussian_blur_test;
   import gblur_pkg::*;

   localparam int STORE_COLS = 1024;
   localparam int STORE_ROWS = 5;
   // Longest time the block may still be busy with an item that gives no result.
   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_CYCLES   = 400;

   // One complete register setting of the block.
   typedef struct {
      logic [10:0] width;
      logic [12:0] height;
      logic [2:0]  side;
      logic [15:0] scale;
      logic [63:0] coef0;
      logic [63:0] coef1;
      logic [63:0] coef2;
      logic [7:0]  coef3;
   } setup_type;

   // A row of the directed table. Where spelt_out is set, the expected result is
   // given in the row itself rather than worked out by the blur predictor.
   typedef struct {
      int         setup_no;
      logic       kind;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      bit         spelt_out;
      bit         gives_result;
      logic [7:0] grey;
      logic       last;
   } row_type;

   typedef struct {
      bit         spelt_out;
      bit         gives_result;
      logic [7:0] grey;
      logic       last;
   } note_type;

   typedef struct {
      logic [7:0] grey;
      logic       last;
   } pixel_out_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // red_in, green_in, blue_in
   logic        req_tuser;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // blurred_grey
   logic        rsp_tlast;   // last_of_frame
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic        csr_pready;

   grey_gaussian_blur DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // The whole run is far shorter than this.
   initial begin
      #200_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Blur predictor: its own copy of the registers and of the line store.
   // ------------------------------------------------------------------
   logic [10:0] bl_width;
   logic [12:0] bl_height;
   logic [2:0]  bl_side;
   logic [15:0] bl_scale;
   logic [63:0] bl_coef [0:3];
   logic [7:0]  grey_rows [0:STORE_ROWS*STORE_COLS-1];
   int unsigned next_in_col, next_in_row, next_out_col, next_out_row;
   bit          frame_received;

   pixel_out_type awaited_pixels [$];   // expected results, oldest first
   note_type      offered_notes [$];    // one per item offered, popped on its transfer
   int            failures;

   bit          no_gaps;              // stretch with no idling on either side
   bit          hold_request;         // asks the receiver for one long hold-off

   function automatic int unsigned used_width();
      if (bl_width == 0) return 1;
      if (bl_width > STORE_COLS) return STORE_COLS;
      return bl_width;
   endfunction

   function automatic int unsigned used_height();
      return (bl_height == 0) ? 1 : bl_height;
   endfunction

   function automatic int unsigned used_side();
      if (bl_side == 0) return 1;
      if (bl_side > STORE_ROWS) return STORE_ROWS;
      return bl_side;
   endfunction

   function automatic int weight_of(int unsigned idx);
      logic [7:0] b;
      if (idx > 24) return 0;
      b = bl_coef[idx / 8][8 * (idx % 8) +: 8];
      return int'($signed(b));
   endfunction

   function automatic logic [7:0] blurred_at(int unsigned row, int unsigned col);
      int acc, a, b, half, scale, w, h;
      int unsigned k;
      w = used_width();
      h = used_height();
      k = used_side();
      half = k / 2;
      scale = (bl_scale == 0) ? 1 : bl_scale;
      acc = 0;
      for (int j = 0; j < k; j++) begin
         for (int i = 0; i < k; i++) begin
            a = int'(col) + i - half;
            b = int'(row) + j - half;
            if (a >= 0 && b >= 0 && a < w && b < h)
               acc += weight_of(j * k + i)
                      * int'(grey_rows[(b % STORE_ROWS) * STORE_COLS + (a % STORE_COLS)]);
         end
      end
      acc = acc / scale;   // truncates toward zero
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      return acc[7:0];
   endfunction

   function automatic pixel_out_type next_blurred();
      pixel_out_type res;
      int unsigned w, h;
      w = used_width();
      h = used_height();
      res.grey = blurred_at(next_out_row, next_out_col);
      res.last = (next_out_row >= h - 1) && (next_out_col >= w - 1);
      if (res.last) begin
         // The frame is complete; the next pixel starts a new one.
         next_in_col = 0;
         next_in_row = 0;
         next_out_col = 0;
         next_out_row = 0;
         frame_received = 0;
      end else begin
         next_out_col++;
         if (next_out_col >= w) begin
            next_out_col = 0;
            next_out_row++;
         end
      end
      return res;
   endfunction

   function automatic bit blur_item(input logic kind, input logic [23:0] rgb,
                                    output pixel_out_type res);
      int unsigned w, h, k, d, lag, pos;
      res.grey = '0;
      res.last = 1'b0;
      if (kind == KIND_DRAIN) begin
         // A drain only counts once every pixel of the frame has arrived.
         if (!frame_received) return 0;
         res = next_blurred();
         return 1;
      end
      // Extra pixels after the frame but before its drain are dropped.
      if (frame_received) return 0;
      w = used_width();
      h = used_height();
      if (next_in_col >= w) begin
         next_in_col = 0;
         next_in_row++;
      end
      if (next_in_row >= h) next_in_row = h - 1;
      grey_rows[(next_in_row % STORE_ROWS) * STORE_COLS + (next_in_col % STORE_COLS)]
         = 8'((int'(rgb[7:0]) + int'(rgb[15:8]) + int'(rgb[23:16])) / 3);
      k = used_side();
      d = k - 1 - k / 2;
      lag = d * w + d;
      pos = next_in_row * w + next_in_col;
      next_in_col++;
      if (next_in_col >= w) begin
         next_in_col = 0;
         next_in_row++;
         if (next_in_row >= h) frame_received = 1;
      end
      if (pos >= lag) begin
         res = next_blurred();
         return 1;
      end
      return 0;
   endfunction

   initial begin
      for (int i = 0; i < STORE_ROWS * STORE_COLS; i++) grey_rows[i] = '0;
      next_in_col = 0;
      next_in_row = 0;
      next_out_col = 0;
      next_out_row = 0;
      frame_received = 0;
      bl_width = 11'd640;
      bl_height = 13'd480;
      bl_side = 3'd5;
      bl_scale = 16'd1;
      for (int i = 0; i < 4; i++) bl_coef[i] = '0;
      failures = 0;
   end

   // Register writes and accepted items are fed to the predictor at the very
   // edge at which the block takes them.
   always @(posedge clock) begin
      pixel_out_type res;
      note_type      note;
      bit            gives;
      if (!reset && csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_paddr[5:3])
            REG_WIDTH:  bl_width  <= csr_pwdata[10:0];
            REG_HEIGHT: bl_height <= csr_pwdata[12:0];
            REG_SIDE:   bl_side   <= csr_pwdata[2:0];
            REG_SCALE:  bl_scale  <= csr_pwdata[15:0];
            REG_COEF0:  bl_coef[0] <= csr_pwdata;
            REG_COEF1:  bl_coef[1] <= csr_pwdata;
            REG_COEF2:  bl_coef[2] <= csr_pwdata;
            REG_COEF3:  bl_coef[3] <= {56'd0, csr_pwdata[7:0]};
            default: ;
         endcase
      end
      if (!reset && req_tvalid && req_tready) begin
         note = offered_notes.pop_front();
         gives = blur_item(req_tuser, req_tdata, res);
         if (note.spelt_out) begin
            gives = note.gives_result;
            res.grey = note.grey;
            res.last = note.last;
         end
         if (gives) awaited_pixels.push_back(res);
      end
   end

   // Every result transfer is compared with the oldest expectation.
   always @(posedge clock) begin
      pixel_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_pixels.size() == 0) begin
            $display("%0t: unexpected result grey=%0d last=%0b", $time, rsp_tdata, rsp_tlast);
            failures++;
         end else begin
            want = awaited_pixels.pop_front();
            if (rsp_tdata !== want.grey) begin
               $display("%0t: blurred_grey expected %0d, got %0d", $time, want.grey, rsp_tdata);
               failures++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last_of_frame expected %0b, got %0b", $time, want.last, rsp_tlast);
               failures++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stalls per result, and one long hold-off on request.
   // ------------------------------------------------------------------
   initial begin
      int stall;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = no_gaps ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------
   // Sender and register writes.
   // ------------------------------------------------------------------
   task automatic offer_item(input logic kind, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input note_type note);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      offered_notes.push_back(note);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {b, g, r};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic offer_checked(input logic kind, input logic [23:0] rgb);
      note_type note;
      note = '{0, 0, 8'd0, 1'b0};
      offer_item(kind, rgb[7:0], rgb[15:8], rgb[23:16], note);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Waits until every expected result has arrived and the block has had time
   // to finish any item that gives none.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_pixels.size() != 0 || offered_notes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_setup(input setup_type s);
      settle();
      write_register(REG_WIDTH, 64'(s.width));
      write_register(REG_HEIGHT, 64'(s.height));
      write_register(REG_SIDE, 64'(s.side));
      write_register(REG_SCALE, 64'(s.scale));
      write_register(REG_COEF0, s.coef0);
      write_register(REG_COEF1, s.coef1);
      write_register(REG_COEF2, s.coef2);
      write_register(REG_COEF3, 64'(s.coef3));
   endtask

   // Sends one whole frame with random content, a little noise that the block must
   // ignore when noisy is set, and just enough drain items to flush it.
   task automatic run_frame(input setup_type s, input bit noisy);
      int unsigned w, h, k, d, lag, n, from_pixels;
      load_setup(s);
      w = (s.width == 0) ? 1 : ((s.width > STORE_COLS) ? STORE_COLS : s.width);
      h = (s.height == 0) ? 1 : s.height;
      k = (s.side == 0) ? 1 : ((s.side > STORE_ROWS) ? STORE_ROWS : s.side);
      d = k - 1 - k / 2;
      lag = d * w + d;
      n = w * h;
      from_pixels = (n > lag) ? n - lag : 0;
      for (int unsigned p = 0; p < n; p++) begin
         // A drain item in the middle of the frame is ignored.
         if (noisy && $urandom_range(0, 9) == 0) offer_checked(KIND_DRAIN, 24'($urandom));
         offer_checked(KIND_PIXEL, 24'($urandom));
      end
      if (n - from_pixels > 0 && noisy && $urandom_range(0, 2) == 0)
         offer_checked(KIND_PIXEL, 24'($urandom));
      for (int unsigned p = 0; p < n - from_pixels; p++)
         offer_checked(KIND_DRAIN, 24'($urandom));
      if (noisy && $urandom_range(0, 3) == 0) offer_checked(KIND_DRAIN, 24'($urandom));
   endtask

   function automatic setup_type random_setup();
      setup_type s;
      int unsigned total;
      s.width  = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
      s.height = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 5));
      s.side   = 3'($urandom_range(0, 7));
      s.coef0  = {$urandom, $urandom};
      s.coef1  = {$urandom, $urandom};
      s.coef2  = {$urandom, $urandom};
      s.coef3  = 8'($urandom);
      s.scale  = 16'($urandom_range(1, 64));
      if ($urandom_range(0, 1) == 0) begin
         // Small positive weights with a matching divisor, a true blur.
         total = 0;
         for (int i = 0; i < 8; i++) begin
            s.coef0[8*i +: 8] = 8'($urandom_range(0, 15));
            s.coef1[8*i +: 8] = 8'($urandom_range(0, 15));
            s.coef2[8*i +: 8] = 8'($urandom_range(0, 15));
            total += s.coef0[8*i +: 8] + s.coef1[8*i +: 8] + s.coef2[8*i +: 8];
         end
         s.coef3 = 8'($urandom_range(0, 15));
         total += s.coef3;
         s.scale = (total == 0) ? 16'd1 : 16'(total);
      end
      case ($urandom_range(0, 19))
         0: s.scale = 16'd0;
         1: s.scale = 16'hFFFF;
         default: ;
      endcase
      return s;
   endfunction

   row_type   directed [$];
   setup_type directed_setups [0:1];

   task automatic add_row(input int setup_no, input logic kind, input logic [7:0] r,
                          input logic [7:0] g, input logic [7:0] b, input bit spelt_out,
                          input bit gives_result, input logic [7:0] grey, input logic last);
      row_type row;
      row = '{setup_no, kind, r, g, b, spelt_out, gives_result, grey, last};
      directed.push_back(row);
   endtask

   initial begin
      setup_type s;
      note_type  note;
      int        current_setup;
      int        random_pixels;
      int        frame_no;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = KIND_PIXEL;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      no_gaps     = 0;
      hold_request = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Setting 0: a 3 x 2 frame through a single unit weight, so every result
      // is just the grey value of its own pixel and appears at once.
      directed_setups[0] = '{11'd3, 13'd2, 3'd1, 16'd1, 64'h01, 64'h0, 64'h0, 8'h0};
      // Setting 1: a 3 x 3 frame with the classic 1-2-1 blur, divided by 16.
      directed_setups[1] = '{11'd3, 13'd3, 3'd3, 16'd16,
                             64'h02_01_02_04_02_01_02_01, 64'h01, 64'h0, 8'h0};

      // A drain before the frame has ended gives nothing.
      add_row(0, KIND_DRAIN, 8'd9, 8'd9, 8'd9, 1, 0, 8'd0, 1'b0);
      add_row(0, KIND_PIXEL, 8'd0, 8'd0, 8'd0, 1, 1, 8'd0, 1'b0);
      add_row(0, KIND_PIXEL, 8'd255, 8'd255, 8'd255, 1, 1, 8'd255, 1'b0);
      add_row(0, KIND_PIXEL, 8'd255, 8'd0, 8'd0, 1, 1, 8'd85, 1'b0);
      add_row(0, KIND_PIXEL, 8'd0, 8'd255, 8'd0, 1, 1, 8'd85, 1'b0);
      add_row(0, KIND_PIXEL, 8'd0, 8'd0, 8'd255, 1, 1, 8'd85, 1'b0);
      add_row(0, KIND_PIXEL, 8'd254, 8'd255, 8'd255, 1, 1, 8'd254, 1'b1);
      // A drain after the final result of a frame gives nothing either.
      add_row(0, KIND_DRAIN, 8'd0, 8'd0, 8'd0, 1, 0, 8'd0, 1'b0);
      add_row(1, KIND_PIXEL, 8'd10, 8'd20, 8'd30, 0, 0, 8'd0, 1'b0);
      add_row(1, KIND_PIXEL, 8'd255, 8'd255, 8'd255, 0, 0, 8'd0, 1'b0);
      add_row(1, KIND_PIXEL, 8'd0, 8'd0, 8'd0, 0, 0, 8'd0, 1'b0);
      add_row(1, KIND_PIXEL, 8'd128, 8'd64, 8'd32, 0, 0, 8'd0, 1'b0);
      add_row(1, KIND_PIXEL, 8'd255, 8'd255, 8'd255, 0, 0, 8'd0, 1'b0);
      add_row(1, KIND_PIXEL, 8'd1, 8'd2, 8'd3, 0, 0, 8'd0, 1'b0);
      add_row(1, KIND_PIXEL, 8'd200, 8'd100, 8'd50, 0, 0, 8'd0, 1'b0);
      add_row(1, KIND_PIXEL, 8'd0, 8'd255, 8'd0, 0, 0, 8'd0, 1'b0);
      add_row(1, KIND_PIXEL, 8'd170, 8'd85, 8'd255, 0, 0, 8'd0, 1'b0);
      // A pixel after the frame has ended but before its drain is dropped.
      add_row(1, KIND_PIXEL, 8'd77, 8'd77, 8'd77, 0, 0, 8'd0, 1'b0);
      for (int i = 0; i < 4; i++) add_row(1, KIND_DRAIN, 8'd0, 8'd0, 8'd0, 0, 0, 8'd0, 1'b0);

      current_setup = -1;
      foreach (directed[i]) begin
         if (directed[i].setup_no != current_setup) begin
            current_setup = directed[i].setup_no;
            load_setup(directed_setups[current_setup]);
         end
         note = '{directed[i].spelt_out, directed[i].gives_result,
                  directed[i].grey, directed[i].last};
         offer_item(directed[i].kind, directed[i].red, directed[i].green,
                    directed[i].blue, note);
      end

      // Extreme weights: all at the top with the side and the scale out of range,
      // so the sums saturate, then all at the bottom with the largest divisor.
      s = '{11'd4, 13'd3, 3'd7, 16'd0, 64'h7F7F_7F7F_7F7F_7F7F, 64'h7F7F_7F7F_7F7F_7F7F,
            64'h7F7F_7F7F_7F7F_7F7F, 8'h7F};
      run_frame(s, 0);
      s = '{11'd3, 13'd2, 3'd3, 16'hFFFF, 64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080,
            64'h8080_8080_8080_8080, 8'h80};
      run_frame(s, 0);

      // Random frames, mostly small, with stretches of no idling and one long
      // hold-off of the receiver while the sender keeps offering items.
      random_pixels = 0;
      frame_no = 0;
      while (random_pixels < 250) begin
         s = random_setup();
         no_gaps = ($urandom_range(0, 3) == 0);
         if (frame_no == 3) begin
            s.width = 11'd6;
            s.height = 13'd4;
            s.side = 3'd1;
            no_gaps = 1;
            settle();
            hold_request = 1;
         end
         run_frame(s, 1);
         random_pixels += ((s.width == 0) ? 1 : s.width) * ((s.height == 0) ? 1 : s.height);
         frame_no++;
      end
      no_gaps = 0;

      settle();
      if (awaited_pixels.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, awaited_pixels.size());
         failures++;
      end
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
